### rtl/msd_pkg.sv
// Shared types, constants and helpers for the mean squared displacement block.
package msd_pkg;

    localparam int MAX_FRAMES_DEF    = 64;
    localparam int MAX_ATOMS_DEF     = 1024;
    localparam int POS_FRAC_BITS_DEF = 16;

    localparam int POS_W      = 32;
    localparam int IMG_W      = 10;
    localparam int TSTEP_W    = 31;
    localparam int UNW_W      = 48;
    localparam int ACC_W      = 64;
    localparam int TIME_W     = 32;
    localparam int LAG_W      = 6;
    localparam int FRAME_W    = 6;
    localparam int ATOM_W     = 10;
    localparam int FC_W       = 7;
    localparam int AC_W       = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 176;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 296;

    typedef enum logic [1:0] {
        CMD_BOX_LEN,
        CMD_BOX_TILT,
        CMD_ATOM,
        CMD_COMPUTE
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRICLINIC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_ALL  = 3'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW0,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic issue;
        logic clear;
    } sq_ctrl_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage

### rtl/msd_store.sv
// Load path (unwrap pipeline) and the position, selection and timestep memories.
module msd_store import msd_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
    localparam int FRAME_AW  = $clog2(MAX_FRAMES),
    localparam int ATOM_AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
    localparam int POS_AW    = FRAME_AW + ATOM_AW
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     ld_valid,
    input  cmd_t                     ld_cmd,
    input  logic [FRAME_W-1:0]       ld_frame,
    input  logic [ATOM_W-1:0]        ld_atom,
    input  logic                     ld_selected,
    input  logic signed [POS_W-1:0]  ld_pos_x,
    input  logic signed [POS_W-1:0]  ld_pos_y,
    input  logic signed [POS_W-1:0]  ld_pos_z,
    input  logic signed [IMG_W-1:0]  ld_img_x,
    input  logic signed [IMG_W-1:0]  ld_img_y,
    input  logic signed [IMG_W-1:0]  ld_img_z,
    input  logic [TSTEP_W-1:0]       ld_time_step,
    input  logic                     triclinic,
    input  logic                     select_all,
    input  logic                     clr_en,
    input  logic [ATOM_AW-1:0]       clr_addr,
    input  logic [POS_AW-1:0]        rd_addr0,
    input  logic [POS_AW-1:0]        rd_addr1,
    input  logic [ATOM_AW-1:0]       mask_addr,
    input  logic [FRAME_AW-1:0]      time_addr0,
    input  logic [FRAME_AW-1:0]      time_addr1,
    output logic [3*UNW_W-1:0]       rd_data0,
    output logic [3*UNW_W-1:0]       rd_data1,
    output logic                     mask_bit,
    output logic [TIME_W-1:0]        time_data0,
    output logic [TIME_W-1:0]        time_data1
);

    localparam int PROD_W    = POS_W + IMG_W;
    localparam int POS_DEPTH = MAX_FRAMES << ATOM_AW;

    logic [3*UNW_W-1:0] pos_mem [POS_DEPTH];
    logic               mask_mem [MAX_ATOMS];
    logic [TIME_W-1:0]  time_mem [MAX_FRAMES];

    logic signed [POS_W-1:0] box_len_reg [3];
    logic signed [POS_W-1:0] tilt_reg [3];

    logic fr_ok, at_ok;
    logic [FRAME_AW-1:0] fr_idx;
    logic [ATOM_AW-1:0]  at_idx;

    // stage 1: products
    logic s1_pos_we_reg, s1_mask_we_reg, s1_time_we_reg;
    logic [POS_AW-1:0]       s1_addr_reg;
    logic [ATOM_AW-1:0]      s1_atom_reg;
    logic [FRAME_AW-1:0]     s1_taddr_reg;
    logic [TIME_W-1:0]       s1_tdata_reg;
    logic signed [POS_W-1:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic signed [PROD_W-1:0] s1_lx_reg, s1_ly_reg, s1_lz_reg;
    logic signed [PROD_W-1:0] s1_xy_reg, s1_xz_reg, s1_yz_reg;
    logic signed [PROD_W-1:0] lx_next, ly_next, lz_next, xy_next, xz_next, yz_next;

    // stage 2: partial sums
    logic s2_pos_we_reg, s2_mask_we_reg;
    logic [POS_AW-1:0]        s2_addr_reg;
    logic [ATOM_AW-1:0]       s2_atom_reg;
    logic signed [UNW_W-1:0]  s2_xa_reg, s2_xb_reg, s2_ya_reg, s2_yb_reg, s2_z_reg;
    logic signed [UNW_W-1:0]  ux, uy;

    logic               mask_we, mask_wd;
    logic [ATOM_AW-1:0] mask_wa;

    assign fr_ok  = 32'(ld_frame) < MAX_FRAMES;
    assign at_ok  = 32'(ld_atom) < MAX_ATOMS;
    assign fr_idx = FRAME_AW'(ld_frame);
    assign at_idx = ATOM_AW'(ld_atom);

    assign lx_next = ld_img_x * box_len_reg[0];
    assign ly_next = ld_img_y * box_len_reg[1];
    assign lz_next = ld_img_z * box_len_reg[2];
    // signed zero keeps the tilt products signed
    assign xy_next = triclinic ? ld_img_y * tilt_reg[0] : PROD_W'(0);
    assign xz_next = triclinic ? ld_img_z * tilt_reg[1] : PROD_W'(0);
    assign yz_next = triclinic ? ld_img_z * tilt_reg[2] : PROD_W'(0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_len_reg[i] <= '0;
                tilt_reg[i]    <= '0;
            end
            s1_pos_we_reg  <= 1'b0;
            s1_mask_we_reg <= 1'b0;
            s1_time_we_reg <= 1'b0;
            s2_pos_we_reg  <= 1'b0;
            s2_mask_we_reg <= 1'b0;
        end else begin
            s1_pos_we_reg  <= ld_valid && ld_cmd == CMD_ATOM && fr_ok && at_ok;
            s1_mask_we_reg <= ld_valid && ld_cmd == CMD_ATOM && fr_ok && at_ok &&
                              !ld_selected && (select_all || ld_frame == '0);
            s1_time_we_reg <= ld_valid && ld_cmd == CMD_BOX_LEN && fr_ok;
            s2_pos_we_reg  <= s1_pos_we_reg;
            s2_mask_we_reg <= s1_mask_we_reg;
            if (ld_valid && fr_ok && ld_cmd == CMD_BOX_LEN) begin
                box_len_reg[0] <= ld_pos_x;
                box_len_reg[1] <= ld_pos_y;
                box_len_reg[2] <= ld_pos_z;
            end
            if (ld_valid && fr_ok && ld_cmd == CMD_BOX_TILT) begin
                tilt_reg[0] <= ld_pos_x;
                tilt_reg[1] <= ld_pos_y;
                tilt_reg[2] <= ld_pos_z;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg  <= {fr_idx, at_idx};
        s1_atom_reg  <= at_idx;
        s1_taddr_reg <= fr_idx;
        s1_tdata_reg <= {1'b0, ld_time_step};
        s1_px_reg    <= ld_pos_x;
        s1_py_reg    <= ld_pos_y;
        s1_pz_reg    <= ld_pos_z;
        s1_lx_reg    <= lx_next;
        s1_ly_reg    <= ly_next;
        s1_lz_reg    <= lz_next;
        s1_xy_reg    <= xy_next;
        s1_xz_reg    <= xz_next;
        s1_yz_reg    <= yz_next;

        s2_addr_reg <= s1_addr_reg;
        s2_atom_reg <= s1_atom_reg;
        s2_xa_reg   <= UNW_W'(s1_px_reg) + UNW_W'(s1_lx_reg);
        s2_xb_reg   <= UNW_W'(s1_xy_reg) + UNW_W'(s1_xz_reg);
        s2_ya_reg   <= UNW_W'(s1_py_reg) + UNW_W'(s1_ly_reg);
        s2_yb_reg   <= UNW_W'(s1_yz_reg);
        s2_z_reg    <= UNW_W'(s1_pz_reg) + UNW_W'(s1_lz_reg);
    end

    assign ux = s2_xa_reg + s2_xb_reg;
    assign uy = s2_ya_reg + s2_yb_reg;

    // clearing pass owns the mask port after reset
    assign mask_we = clr_en || s2_mask_we_reg;
    assign mask_wa = clr_en ? clr_addr : s2_atom_reg;
    assign mask_wd = clr_en;

    always_ff @(posedge aclk) begin
        if (s2_pos_we_reg) begin
            pos_mem[s2_addr_reg] <= {s2_z_reg, uy, ux};
        end
        rd_data0 <= pos_mem[rd_addr0];
        rd_data1 <= pos_mem[rd_addr1];
    end

    always_ff @(posedge aclk) begin
        if (mask_we) begin
            mask_mem[mask_wa] <= mask_wd;
        end
        mask_bit <= mask_mem[mask_addr];
    end

    always_ff @(posedge aclk) begin
        if (s1_time_we_reg) begin
            time_mem[s1_taddr_reg] <= s1_tdata_reg;
        end
        time_data0 <= time_mem[time_addr0];
        time_data1 <= time_mem[time_addr1];
    end

endmodule

### rtl/msd_sqacc.sv
// Displacement, squaring pipeline and saturating accumulators for one lag.
module msd_sqacc import msd_pkg::*; #(
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
    parameter int PC_W          = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sq_ctrl_t               ctrl,
    input  logic [3*UNW_W-1:0]     rd_data0,
    input  logic [3*UNW_W-1:0]     rd_data1,
    input  logic                   mask_bit,
    output logic                   busy,
    output logic [3:0][ACC_W-1:0]  acc,
    output logic [PC_W-1:0]        pair_cnt
);

    localparam int DIFF_W = UNW_W + 1;
    localparam int LO_W   = (DIFF_W + 1) / 2;
    localparam int HI_W   = DIFF_W - LO_W;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int EXT_W  = SQ_W + 32;
    localparam int FRAC2  = 2 * POS_FRAC_BITS;

    logic [8:1] v_reg;

    logic signed [DIFF_W-1:0] diff_reg [3];
    logic [DIFF_W-1:0]        abs_reg [3];
    logic [2*LO_W-1:0]        ll_reg [3];
    logic [LO_W+HI_W-1:0]     lh_reg [3];
    logic [2*HI_W-1:0]        hh4_reg [3];
    logic [SQ_W-1:0]          t_reg [3];
    logic [2*HI_W-1:0]        hh5_reg [3];
    logic [ACC_W-1:0]         q_reg [3];
    logic [ACC_W-1:0]         s7_reg [3];
    logic [ACC_W-1:0]         sxy_reg;
    logic [ACC_W-1:0]         s8_reg [3];
    logic [ACC_W-1:0]         tot_reg;
    logic [3:0][ACC_W-1:0]    acc_reg;
    logic [PC_W-1:0]          pc_reg;

    logic [SQ_W-1:0]  sq [3];
    logic [EXT_W-1:0] wide [3];
    logic [ACC_W-1:0] q_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq[i]     = t_reg[i] + (SQ_W'(hh5_reg[i]) << (2 * LO_W));
            // Q(2F) to Q32
            wide[i]   = {sq[i], 32'b0} >> FRAC2;
            q_next[i] = (|wide[i][EXT_W-1:ACC_W]) ? {ACC_W{1'b1}} : wide[i][ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[7:2], v_reg[1] && mask_bit, ctrl.issue};
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            diff_reg[i] <= DIFF_W'($signed(rd_data1[i*UNW_W +: UNW_W]))
                         - DIFF_W'($signed(rd_data0[i*UNW_W +: UNW_W]));
            abs_reg[i]  <= diff_reg[i][DIFF_W-1] ? DIFF_W'(-diff_reg[i])
                                                 : DIFF_W'(diff_reg[i]);
            ll_reg[i]   <= abs_reg[i][LO_W-1:0] * abs_reg[i][LO_W-1:0];
            lh_reg[i]   <= abs_reg[i][LO_W-1:0] * abs_reg[i][DIFF_W-1:LO_W];
            hh4_reg[i]  <= abs_reg[i][DIFF_W-1:LO_W] * abs_reg[i][DIFF_W-1:LO_W];
            t_reg[i]    <= SQ_W'(ll_reg[i]) + (SQ_W'(lh_reg[i]) << (LO_W + 1));
            hh5_reg[i]  <= hh4_reg[i];
            q_reg[i]    <= q_next[i];
            s7_reg[i]   <= q_reg[i];
            s8_reg[i]   <= s7_reg[i];
        end
        sxy_reg <= sat_add(q_reg[0], q_reg[1]);
        tot_reg <= sat_add(sxy_reg, s7_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            pc_reg  <= '0;
        end else if (ctrl.clear) begin
            acc_reg <= '0;
            pc_reg  <= '0;
        end else if (v_reg[8]) begin
            acc_reg[0] <= sat_add(acc_reg[0], s8_reg[0]);
            acc_reg[1] <= sat_add(acc_reg[1], s8_reg[1]);
            acc_reg[2] <= sat_add(acc_reg[2], s8_reg[2]);
            acc_reg[3] <= sat_add(acc_reg[3], tot_reg);
            pc_reg     <= pc_reg + PC_W'(1);
        end
    end

    assign busy     = |v_reg;
    assign acc      = acc_reg;
    assign pair_cnt = pc_reg;

endmodule

### rtl/msd_div.sv
// Four-lane restoring divider sharing one divisor, one quotient bit per cycle.
module msd_div import msd_pkg::*; #(
    parameter int PC_W = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [3:0][ACC_W-1:0] dividend,
    input  logic [PC_W-1:0]       divisor,
    output logic                  busy,
    output logic [3:0][ACC_W-1:0] quot
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PC_W-1:0]       d_reg;
    logic [3:0][ACC_W-1:0] q_reg;
    logic [3:0][PC_W-1:0]  rem_reg;

    logic [3:0][PC_W:0]    rs;
    logic [3:0]            qbit;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rs[i]   = {rem_reg[i], q_reg[i][ACC_W-1]};
            qbit[i] = rs[i] >= {1'b0, d_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CNT_W'(ACC_W);
            d_reg   <= divisor;
            q_reg   <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            for (int i = 0; i < 4; i++) begin
                q_reg[i]   <= {q_reg[i][ACC_W-2:0], qbit[i]};
                rem_reg[i] <= qbit[i] ? PC_W'(rs[i] - {1'b0, d_reg}) : PC_W'(rs[i]);
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

### rtl/mean_squared_displacement_lags.sv
// Load records: one per cycle while idle; each atom record is written after the product
// and partial-sum stages. Compute: row 0 then, per lag k, (frame_count-k)*atom_count
// atom pairs read one pair per cycle from the dual-read position memory, a pipeline
// drain and a pass through the shared divider before the row is offered.
// Reset: after aresetn the selection mask is set to ones, one atom a cycle, for all
// MAX_ATOMS atoms; no item is taken until then, configuration writes are taken always.
module mean_squared_displacement_lags import msd_pkg::*; #(
    parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
    parameter int MAX_ATOMS     = MAX_ATOMS_DEF,
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // frame, atom, selected, pos_x, pos_y, pos_z, img_x, img_y, img_z, time_step
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lag, time_delta, mean_sq_x, mean_sq_y, mean_sq_z, mean_sq_total
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FRAME_AW = $clog2(MAX_FRAMES);
    localparam int ATOM_AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int POS_AW   = FRAME_AW + ATOM_AW;
    localparam int NF_W     = $clog2(MAX_FRAMES + 1);
    localparam int NA_W     = $clog2(MAX_ATOMS + 1);
    localparam int PC_W     = $clog2((MAX_FRAMES - 1) * MAX_ATOMS + 1);

    // configuration
    logic [FC_W-1:0] cfg_frame_count_reg;
    logic [AC_W-1:0] cfg_atom_count_reg;
    logic            cfg_triclinic_reg;
    logic            cfg_select_all_reg;

    state_t state_reg, state_next;
    logic [NF_W-1:0]    k_reg, k_next, r_reg, r_next, nf_reg, nf_next, nf_sel;
    logic [ATOM_AW-1:0] a_reg, a_next, clr_cnt_reg, clr_cnt_next;
    logic [NA_W-1:0]    na_reg, na_next, na_sel;

    logic                  m_valid_reg;
    logic [LAG_W-1:0]      m_lag_reg, out_lag_next;
    logic [TIME_W-1:0]     m_td_reg, out_td_next;
    logic [3:0][ACC_W-1:0] m_mean_reg, out_mean_next;
    logic                  m_last_reg, out_last_next;
    logic                  out_load, out_free;

    logic       s_accept, ld_valid, clr_en, div_start;
    cmd_t       in_cmd;
    sq_ctrl_t   sq_ctrl;
    logic       a_last, r_last;
    logic [NF_W-1:0] rk;

    logic [POS_AW-1:0]     rd_addr0, rd_addr1;
    logic [FRAME_AW-1:0]   time_addr0, time_addr1;
    logic [3*UNW_W-1:0]    rd_data0, rd_data1;
    logic                  mask_bit;
    logic [TIME_W-1:0]     time_data0, time_data1;
    logic                  sq_busy, div_busy;
    logic [3:0][ACC_W-1:0] acc, quot;
    logic [PC_W-1:0]       pair_cnt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_frame_count_reg <= FC_W'(1);
            cfg_atom_count_reg  <= AC_W'(1);
            cfg_triclinic_reg   <= 1'b0;
            cfg_select_all_reg  <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_COUNT: cfg_frame_count_reg <= cfg_data[FC_W-1:0];
                REG_ATOM_COUNT:  cfg_atom_count_reg  <= cfg_data[AC_W-1:0];
                REG_TRICLINIC:   cfg_triclinic_reg   <= cfg_data[0];
                REG_SELECT_ALL:  cfg_select_all_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_cmd   = cmd_t'(s_tuser[1:0]);
    assign ld_valid = s_accept && in_cmd != CMD_COMPUTE;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        if (cfg_frame_count_reg == '0) begin
            nf_sel = NF_W'(1);
        end else if (32'(cfg_frame_count_reg) > MAX_FRAMES) begin
            nf_sel = NF_W'(MAX_FRAMES);
        end else begin
            nf_sel = NF_W'(cfg_frame_count_reg);
        end
        if (32'(cfg_atom_count_reg) > MAX_ATOMS) begin
            na_sel = NA_W'(MAX_ATOMS);
        end else begin
            na_sel = NA_W'(cfg_atom_count_reg);
        end
    end

    assign rk         = r_reg + k_reg;
    assign a_last     = NA_W'(a_reg) == na_reg - NA_W'(1);
    assign r_last     = rk == nf_reg - NF_W'(1);
    assign rd_addr0   = {FRAME_AW'(r_reg), a_reg};
    assign rd_addr1   = {FRAME_AW'(rk), a_reg};
    assign time_addr0 = FRAME_AW'(nf_reg - NF_W'(1));
    assign time_addr1 = FRAME_AW'(nf_reg - NF_W'(1) - k_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            k_reg       <= '0;
            r_reg       <= '0;
            a_reg       <= '0;
            nf_reg      <= NF_W'(1);
            na_reg      <= '0;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            r_reg       <= r_next;
            a_reg       <= a_next;
            nf_reg      <= nf_next;
            na_reg      <= na_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        r_next        = r_reg;
        a_next        = a_reg;
        nf_next       = nf_reg;
        na_next       = na_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_en        = 1'b0;
        sq_ctrl       = '0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        out_lag_next  = LAG_W'(k_reg);
        out_td_next   = '0;
        out_mean_next = '0;
        out_last_next = k_reg == nf_reg - NF_W'(1);

        unique case (state_reg)
            ST_CLEAR: begin
                clr_en       = 1'b1;
                clr_cnt_next = clr_cnt_reg + ATOM_AW'(1);
                if (clr_cnt_reg == ATOM_AW'(MAX_ATOMS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept && in_cmd == CMD_COMPUTE) begin
                    nf_next    = nf_sel;
                    na_next    = na_sel;
                    k_next     = '0;
                    state_next = ST_ROW0;
                end
            end
            ST_ROW0: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (nf_reg == NF_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next        = NF_W'(1);
                        r_next        = '0;
                        a_next        = '0;
                        sq_ctrl.clear = 1'b1;
                        state_next    = (na_reg == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                sq_ctrl.issue = 1'b1;
                if (a_last) begin
                    a_next = '0;
                    if (r_last) begin
                        state_next = ST_DRAIN;
                    end else begin
                        r_next = r_reg + NF_W'(1);
                    end
                end else begin
                    a_next = a_reg + ATOM_AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!sq_busy) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                out_td_next   = time_data0 - time_data1;
                out_mean_next = (pair_cnt == '0) ? '0 : quot;
                if (out_free) begin
                    out_load = 1'b1;
                    if (out_last_next) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next        = k_reg + NF_W'(1);
                        r_next        = '0;
                        a_next        = '0;
                        sq_ctrl.clear = 1'b1;
                        state_next    = (na_reg == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // row 0 goes through with k_reg at zero, so the same fields serve both
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_lag_reg  <= out_lag_next;
            m_td_reg   <= out_td_next;
            m_mean_reg <= out_mean_next;
            m_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_mean_reg[3], m_mean_reg[2], m_mean_reg[1], m_mean_reg[0],
                       m_td_reg, m_lag_reg};

    msd_store #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_ATOMS  (MAX_ATOMS)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ld_valid     (ld_valid),
        .ld_cmd       (in_cmd),
        .ld_frame     (s_tdata[5:0]),
        .ld_atom      (s_tdata[15:6]),
        .ld_selected  (s_tdata[16]),
        .ld_pos_x     ($signed(s_tdata[48:17])),
        .ld_pos_y     ($signed(s_tdata[80:49])),
        .ld_pos_z     ($signed(s_tdata[112:81])),
        .ld_img_x     ($signed(s_tdata[122:113])),
        .ld_img_y     ($signed(s_tdata[132:123])),
        .ld_img_z     ($signed(s_tdata[142:133])),
        .ld_time_step (s_tdata[173:143]),
        .triclinic    (cfg_triclinic_reg),
        .select_all   (cfg_select_all_reg),
        .clr_en       (clr_en),
        .clr_addr     (clr_cnt_reg),
        .rd_addr0     (rd_addr0),
        .rd_addr1     (rd_addr1),
        .mask_addr    (a_reg),
        .time_addr0   (time_addr0),
        .time_addr1   (time_addr1),
        .rd_data0     (rd_data0),
        .rd_data1     (rd_data1),
        .mask_bit     (mask_bit),
        .time_data0   (time_data0),
        .time_data1   (time_data1)
    );

    msd_sqacc #(
        .POS_FRAC_BITS (POS_FRAC_BITS),
        .PC_W          (PC_W)
    ) u_sqacc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (sq_ctrl),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1),
        .mask_bit (mask_bit),
        .busy     (sq_busy),
        .acc      (acc),
        .pair_cnt (pair_cnt)
    );

    msd_div #(
        .PC_W (PC_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc),
        .divisor  (pair_cnt),
        .busy     (div_busy),
        .quot     (quot)
    );

    a_div_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !sq_busy)
        else $error("divider started with squares still in flight");

    a_quiet_during_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (!sq_busy && !sq_ctrl.issue))
        else $error("accumulators moved while dividing");

    a_lag_row_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && state_reg == ST_EMIT) |-> (k_reg != '0))
        else $error("lag row emitted with lag zero");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_last_next) |=> (state_reg == ST_IDLE))
        else $error("run did not end after the final row");

endmodule
